// ===== rtl/core/quoted_word_tokenizer_unit_assert.svh =====
// Assertion macros for the checker of the tokenizer.
`ifndef QUOTED_WORD_TOKENIZER_UNIT_ASSERT_SVH
`define QUOTED_WORD_TOKENIZER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define QWT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define QWT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/qwt_pkg.sv =====
`timescale 1ns / 1ps

package qwt_pkg;

    localparam int BYTE_W      = 8;
    localparam int LIMIT_W     = 8;
    localparam int NUM_W       = 7;
    localparam int MAX_WORDS_D = 128;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
    localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;

    typedef enum logic [2:0] {
        SCAN_OUT    = 3'b001,
        SCAN_WORD   = 3'b010,
        SCAN_QUOTED = 3'b100
    } t_scan;

    typedef enum logic [2:0] {
        ESC_NONE   = 3'b001,
        ESC_BSLASH = 3'b010,
        ESC_CARET  = 3'b100
    } t_esc;

    // C-locale whitespace: tab, newline, vertical tab, form feed, return, space.
    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [BYTE_W-1:0] backslash_map(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        case (c)
            8'h61:   r = 8'd7;   // a
            8'h6E:   r = 8'd10;  // n
            8'h74:   r = 8'd9;   // t
            8'h72:   r = 8'd13;  // r
            8'h66:   r = 8'd12;  // f
            8'h62:   r = 8'd8;   // b
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] caret_map(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c == CH_QMARK) begin
            r = CH_DEL;
        end else if (c >= CH_AT && c <= CH_UNDER) begin
            r = c - 8'h40;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h60;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/qwt_if.sv =====
`timescale 1ns / 1ps

interface qwt_in_if;
    import qwt_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              last_byte;
    modport source (output valid, in_byte, last_byte, input ready);
    modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface qwt_out_if;
    import qwt_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              word_start;
    logic              word_end;
    logic [NUM_W-1:0]  word_number;
    logic              line_done;
    logic              overflow;
    modport source (output valid, out_byte, has_byte, word_start, word_end, word_number,
                    line_done, overflow, input ready);
    modport sink   (input valid, out_byte, has_byte, word_start, word_end, word_number,
                    line_done, overflow, output ready);
endinterface

interface qwt_cfg_if;
    import qwt_pkg::*;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] word_limit;
    modport source (output valid, word_limit, input ready);
    modport sink   (input valid, word_limit, output ready);
endinterface

// ===== rtl/core/quoted_word_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// A beat taken on i_in is held in the input register and loaded into the result
// register once that register is free or being drained; its result is then on o_out.
// Throughput: one byte per cycle while o_out is not stalled; during a stall the input
// register still takes a new beat if it is empty, and bytes that give no result leave no gap.
// Reset (synchronous, active low) empties both registers, returns the parser to
// outside-word and sets the word limit to 128.

module quoted_word_tokenizer_unit #(
    parameter int MAX_WORDS = qwt_pkg::MAX_WORDS_D
) (
    input logic      i_clk,
    input logic      i_rst_n,
    qwt_in_if.sink   i_in,
    qwt_cfg_if.sink  i_cfg,
    qwt_out_if.source o_out
);
    import qwt_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Parser state.
    t_scan              r_scan,   n_scan;
    t_esc               r_esc,    n_esc;
    logic               r_close_single, n_close_single;
    logic               r_swallow, n_swallow;
    logic [LIMIT_W-1:0] r_words,  n_words;
    logic               r_stopped, n_stopped;
    logic [LIMIT_W-1:0] r_limit;

    // Result register.
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_has_byte;
    logic              r_word_start;
    logic              r_word_end;
    logic [NUM_W-1:0]  r_word_number;
    logic              r_line_done;
    logic              r_overflow;

    logic               advance;
    logic [LIMIT_W-1:0] eff_limit;
    logic               is_quote;
    logic [BYTE_W-1:0]  closer;
    logic [BYTE_W-1:0]  ob;
    logic               hb, ws, we, ov;
    logic [NUM_W-1:0]   num;
    logic               res_valid;
    logic [LIMIT_W-1:0] words_m1;

    // The held byte moves on whenever the result register is free or being
    // drained this cycle; a byte that gives no result still needs that slot
    // free, which keeps the ordering simple at no cost in rate.
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // The limit in use is the smaller of the register and the build-time cap.
    assign eff_limit = (r_limit > LIMIT_W'(MAX_WORDS)) ? LIMIT_W'(MAX_WORDS) : r_limit;
    assign is_quote  = (r_in_byte == CH_DQUOTE) || (r_in_byte == CH_SQUOTE);
    assign closer    = r_close_single ? CH_SQUOTE : CH_DQUOTE;

    always_comb begin
        n_scan         = r_scan;
        n_esc          = r_esc;
        n_close_single = r_close_single;
        n_swallow      = r_swallow;
        n_words        = r_words;
        n_stopped      = r_stopped;
        ob = '0;
        hb = 1'b0;
        ws = 1'b0;
        we = 1'b0;
        ov = 1'b0;

        if (r_stopped) begin
            ov = 1'b1;
        end else if (r_swallow) begin
            // The byte straight after a closing quote is dropped unseen.
            n_swallow = 1'b0;
        end else begin
            case (r_scan)
                SCAN_WORD: begin
                    if (is_blank(r_in_byte)) begin
                        we     = 1'b1;
                        n_scan = SCAN_OUT;
                    end else begin
                        hb = 1'b1;
                        ob = r_in_byte;
                    end
                end
                SCAN_QUOTED: begin
                    case (r_esc)
                        ESC_BSLASH: begin
                            hb    = 1'b1;
                            ob    = backslash_map(r_in_byte);
                            n_esc = ESC_NONE;
                        end
                        ESC_CARET: begin
                            hb    = 1'b1;
                            ob    = caret_map(r_in_byte);
                            n_esc = ESC_NONE;
                        end
                        default: begin
                            if (r_in_byte == closer) begin
                                we        = 1'b1;
                                n_scan    = SCAN_OUT;
                                n_swallow = 1'b1;
                            end else if (r_in_byte == CH_BSLASH) begin
                                n_esc = ESC_BSLASH;
                            end else if (r_in_byte == CH_CARET) begin
                                n_esc = ESC_CARET;
                            end else begin
                                hb = 1'b1;
                                ob = r_in_byte;
                            end
                        end
                    endcase
                end
                default: begin
                    // Outside a word: a quote or any non-blank opens one,
                    // unless the word limit has been used up.
                    if (is_quote || !is_blank(r_in_byte)) begin
                        if (r_words >= eff_limit) begin
                            n_stopped = 1'b1;
                            ov        = 1'b1;
                        end else begin
                            n_words = r_words + 1'b1;
                            ws      = 1'b1;
                            if (is_quote) begin
                                n_scan         = SCAN_QUOTED;
                                n_close_single = (r_in_byte == CH_SQUOTE);
                                n_esc          = ESC_NONE;
                            end else begin
                                n_scan = SCAN_WORD;
                                hb     = 1'b1;
                                ob     = r_in_byte;
                            end
                        end
                    end
                end
            endcase
        end

        // A line that ends inside a word closes that word, quoted or not.
        if (r_in_last && !n_stopped && (n_scan == SCAN_WORD || n_scan == SCAN_QUOTED)) begin
            we = 1'b1;
        end

        words_m1 = n_words - 1'b1;
        num = ((hb || ws || we) && (n_words != '0)) ? words_m1[NUM_W-1:0] : '0;

        // The final byte of a line always returns the parser to its idle state.
        if (r_in_last) begin
            n_scan         = SCAN_OUT;
            n_esc          = ESC_NONE;
            n_close_single = 1'b0;
            n_swallow      = 1'b0;
            n_words        = '0;
            n_stopped      = 1'b0;
        end

        res_valid = hb || ws || we || ov || r_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_scan         <= SCAN_OUT;
            r_esc          <= ESC_NONE;
            r_close_single <= 1'b0;
            r_swallow      <= 1'b0;
            r_words        <= '0;
            r_stopped      <= 1'b0;
            r_limit        <= LIMIT_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.word_limit;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_scan         <= n_scan;
                r_esc          <= n_esc;
                r_close_single <= n_close_single;
                r_swallow      <= n_swallow;
                r_words        <= n_words;
                r_stopped      <= n_stopped;
                r_out_valid    <= res_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.last_byte;
        end
        if (advance && res_valid) begin
            r_out_byte    <= ob;
            r_has_byte    <= hb;
            r_word_start  <= ws;
            r_word_end    <= we;
            r_word_number <= num;
            r_line_done   <= r_in_last;
            r_overflow    <= ov;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.has_byte    = r_has_byte;
    assign o_out.word_start  = r_word_start;
    assign o_out.word_end    = r_word_end;
    assign o_out.word_number = r_word_number;
    assign o_out.line_done   = r_line_done;
    assign o_out.overflow    = r_overflow;

endmodule

// ===== rtl/core/qwt_checker.sv =====
`timescale 1ns / 1ps
`include "quoted_word_tokenizer_unit_assert.svh"

module qwt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [qwt_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_has_byte,
    input logic                       i_word_start,
    input logic                       i_word_end,
    input logic                       i_overflow
);
    import qwt_pkg::*;

    logic flags_any;

    assign flags_any = i_has_byte || i_word_start || i_word_end;

    // A stalled result beat stays offered.
    `QWT_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped")
    // Without a word character the byte field reads zero.
    `QWT_ASSERT(a_byte_zero, i_out_valid && !i_has_byte |-> i_out_byte == '0, "stray out_byte")
    // Once stopped, a result carries no word activity.
    `QWT_ASSERT(a_ovf_quiet, i_out_valid && i_overflow |-> !flags_any, "flags in overflow")
    // Reset empties the result register.
    `QWT_ASSERT_ALWAYS(a_rst_empty, $past(!i_rst_n) |-> !i_out_valid, "valid after reset")

endmodule

bind quoted_word_tokenizer_unit qwt_checker u_qwt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_has_byte   (o_out.has_byte),
    .i_word_start (o_out.word_start),
    .i_word_end   (o_out.word_end),
    .i_overflow   (o_out.overflow)
);

// ===== test/qwt_token_checker.sv =====
`timescale 1ns / 1ps

module qwt_token_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [qwt_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_in_last,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [qwt_pkg::LIMIT_W-1:0] i_cfg_limit,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [qwt_pkg::BYTE_W-1:0]  i_out_byte,
    input  logic                        i_out_has_byte,
    input  logic                        i_out_word_start,
    input  logic                        i_out_word_end,
    input  logic [qwt_pkg::NUM_W-1:0]   i_out_word_number,
    input  logic                        i_out_line_done,
    input  logic                        i_out_overflow,
    output int                          o_fail_count,
    output int                          o_pending
);
    import qwt_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              has_ch;
        logic              opens;
        logic              closes;
        logic [NUM_W-1:0]  idx;
        logic              eol;
        logic              ovf;
    } t_token;

    // Tokens still owed by the block, oldest first.
    t_token token_q[$];

    // Shadow copy of the parser state and of the word limit register.
    t_scan              scan_st;
    t_esc               esc_st;
    logic               quote_single;
    logic               skip_next;
    logic [LIMIT_W-1:0] word_cnt;
    logic               halted;
    logic [LIMIT_W-1:0] limit_q;

    function automatic logic space_char(input logic [BYTE_W-1:0] c);
        case (c)
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] bs_expand(input logic [BYTE_W-1:0] c);
        case (c)
            "a":     return 8'h07;
            "b":     return 8'h08;
            "t":     return 8'h09;
            "n":     return 8'h0A;
            "f":     return 8'h0C;
            "r":     return 8'h0D;
            default: return c;
        endcase
    endfunction

    // Both control-letter ranges reduce to the low five bits of the letter.
    function automatic logic [BYTE_W-1:0] caret_expand(input logic [BYTE_W-1:0] c);
        if (c == CH_QMARK) begin
            return CH_DEL;
        end
        if ((c >= CH_AT && c <= CH_UNDER) || (c >= "a" && c <= "z")) begin
            return {3'b000, c[4:0]};
        end
        return c;
    endfunction

    function automatic void reset_parser();
        scan_st      = SCAN_OUT;
        esc_st       = ESC_NONE;
        quote_single = 1'b0;
        skip_next    = 1'b0;
        word_cnt     = '0;
        halted       = 1'b0;
    endfunction

    // Advances the shadow parser by one byte; returns 1 when a token is due.
    function automatic logic tokenize(input logic [BYTE_W-1:0] b, input logic last,
                                      output t_token t);
        logic [LIMIT_W-1:0] cap;
        logic [BYTE_W-1:0]  closer;
        logic               quote;
        t = '0;
        cap = (limit_q > MAX_WORDS_D) ? LIMIT_W'(MAX_WORDS_D) : limit_q;
        closer = quote_single ? CH_SQUOTE : CH_DQUOTE;
        quote = (b == CH_DQUOTE) || (b == CH_SQUOTE);
        if (halted) begin
            t.ovf = 1'b1;
        end else if (skip_next) begin
            skip_next = 1'b0;
        end else if (scan_st == SCAN_WORD) begin
            if (space_char(b)) begin
                t.closes = 1'b1;
                scan_st  = SCAN_OUT;
            end else begin
                t.has_ch = 1'b1;
                t.ch     = b;
            end
        end else if (scan_st == SCAN_QUOTED) begin
            if (esc_st == ESC_BSLASH) begin
                t.has_ch = 1'b1;
                t.ch     = bs_expand(b);
                esc_st   = ESC_NONE;
            end else if (esc_st == ESC_CARET) begin
                t.has_ch = 1'b1;
                t.ch     = caret_expand(b);
                esc_st   = ESC_NONE;
            end else if (b == closer) begin
                t.closes  = 1'b1;
                scan_st   = SCAN_OUT;
                skip_next = 1'b1;
            end else if (b == CH_BSLASH) begin
                esc_st = ESC_BSLASH;
            end else if (b == CH_CARET) begin
                esc_st = ESC_CARET;
            end else begin
                t.has_ch = 1'b1;
                t.ch     = b;
            end
        end else if (quote || !space_char(b)) begin
            if (word_cnt >= cap) begin
                halted = 1'b1;
                t.ovf  = 1'b1;
            end else begin
                word_cnt = word_cnt + 1'b1;
                t.opens  = 1'b1;
                if (quote) begin
                    scan_st      = SCAN_QUOTED;
                    quote_single = (b == CH_SQUOTE);
                    esc_st       = ESC_NONE;
                end else begin
                    scan_st  = SCAN_WORD;
                    t.has_ch = 1'b1;
                    t.ch     = b;
                end
            end
        end
        if (last && !halted && (scan_st == SCAN_WORD || scan_st == SCAN_QUOTED)) begin
            t.closes = 1'b1;
        end
        if ((t.has_ch || t.opens || t.closes) && word_cnt != 0) begin
            t.idx = NUM_W'(word_cnt - 1'b1);
        end
        t.eol = last;
        if (last) begin
            reset_parser();
        end
        return t.has_ch || t.opens || t.closes || t.ovf || last;
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    task automatic compare_token(input t_token want, input t_token got);
        check_field("out_byte", want.ch, got.ch);
        check_field("has_byte", want.has_ch, got.has_ch);
        check_field("word_start", want.opens, got.opens);
        check_field("word_end", want.closes, got.closes);
        check_field("word_number", want.idx, got.idx);
        check_field("line_done", want.eol, got.eol);
        check_field("overflow", want.ovf, got.ovf);
    endtask

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            limit_q = LIMIT_RESET;
            reset_parser();
            token_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.ch     = i_out_byte;
                got.has_ch = i_out_has_byte;
                got.opens  = i_out_word_start;
                got.closes = i_out_word_end;
                got.idx    = i_out_word_number;
                got.eol    = i_out_line_done;
                got.ovf    = i_out_overflow;
                if (token_q.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, actual %h",
                             $time, got);
                    o_fail_count++;
                end else begin
                    want = token_q.pop_front();
                    compare_token(want, got);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (tokenize(i_in_byte, i_in_last, want)) begin
                    token_q.push_back(want);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                limit_q = i_cfg_limit;
            end
        end
        o_pending = token_q.size();
    end

endmodule

// ===== test/quoted_word_tokenizer_unit_test.sv =====
`timescale 1ns / 1ps

module quoted_word_tokenizer_unit_test;
    import qwt_pkg::*;

    // Far beyond the slowest correct run: at most 2140 bytes, each at most
    // one result, with heavy idling on either side and one long output stall.
    localparam int CYCLE_LIMIT  = 600000;
    // Length of the deliberate output stall that backs the block up.
    localparam int HOLD_CYCLES  = 300;
    // A byte that gives no result may still sit in the input register when
    // the last expected beat has left, so the drain waits on past that point.
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;

    qwt_in_if  in_ch();
    qwt_cfg_if cfg_ch();
    qwt_out_if out_ch();

    int fail_count;
    int pending;

    // Idle rates in percent, changed between phases by the stimulus process.
    int tx_idle_pct;
    int rx_idle_pct;
    // Raised by the stimulus to ask the receiver for one long stall.
    bit hold_request;

    int bytes_sent;
    logic [LIMIT_W-1:0] cur_limit;
    // The line being assembled before it is sent.
    logic [BYTE_W-1:0] line_buf[$];

    quoted_word_tokenizer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    qwt_token_checker monitor (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_ch.valid),
        .i_in_ready        (in_ch.ready),
        .i_in_byte         (in_ch.in_byte),
        .i_in_last         (in_ch.last_byte),
        .i_cfg_valid       (cfg_ch.valid),
        .i_cfg_ready       (cfg_ch.ready),
        .i_cfg_limit       (cfg_ch.word_limit),
        .i_out_valid       (out_ch.valid),
        .i_out_ready       (out_ch.ready),
        .i_out_byte        (out_ch.out_byte),
        .i_out_has_byte    (out_ch.has_byte),
        .i_out_word_start  (out_ch.word_start),
        .i_out_word_end    (out_ch.word_end),
        .i_out_word_number (out_ch.word_number),
        .i_out_line_done   (out_ch.line_done),
        .i_out_overflow    (out_ch.overflow),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: if the run has not ended by now, something has hung.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // Result receiver. It normally drops ready at the current idle rate, but when
    // asked it holds off for a long stretch, counting the cycles itself, so that
    // both pipeline registers fill and the block has to refuse input beats.
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request && !hold_taken) begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offers one byte, idling first at the sender's rate, and returns at the
    // falling edge after the beat has been taken. Valid is left high so that
    // back-to-back bytes keep it high without a glitch.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.last_byte <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_byte(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    // The limit may only change while the block is empty: wait for every owed
    // result, then for the pipeline to clear of silent bytes, then write.
    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.word_limit <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_limit = v;
    endtask

    // Extremes turn up often; otherwise anything in the legal range.
    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 8'd1;
            1:       return 8'd128;
            2:       return 8'd2;
            3:       return 8'd3;
            default: return LIMIT_W'($urandom_range(1, 128));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] blank_byte();
        int v;
        v = $urandom_range(9, 14);
        return (v == 14) ? 8'h20 : BYTE_W'(v);
    endfunction

    function automatic logic is_blank_byte(input logic [BYTE_W-1:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [BYTE_W-1:0] any_byte();
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    // A byte that may sit inside an unquoted word.
    function automatic logic [BYTE_W-1:0] word_byte();
        logic [BYTE_W-1:0] c;
        c = any_byte();
        while (is_blank_byte(c)) c = any_byte();
        return c;
    endfunction

    // Plain content of a quoted word: anything but the closer and the two
    // escape prefixes, blanks included.
    function automatic logic [BYTE_W-1:0] quoted_byte(input logic [BYTE_W-1:0] closer);
        logic [BYTE_W-1:0] c;
        c = any_byte();
        while (c == closer || c == CH_BSLASH || c == CH_CARET) c = any_byte();
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] bslash_arg(input logic [BYTE_W-1:0] closer);
        case ($urandom_range(0, 8))
            0:       return "a";
            1:       return "b";
            2:       return "t";
            3:       return "n";
            4:       return "f";
            5:       return "r";
            6:       return closer;
            default: return any_byte();
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] caret_arg();
        case ($urandom_range(0, 4))
            0:       return CH_QMARK;
            1:       return BYTE_W'($urandom_range(CH_AT, CH_UNDER));
            2:       return BYTE_W'($urandom_range("a", "z"));
            default: return any_byte();
        endcase
    endfunction

    task automatic build_plain();
        logic [BYTE_W-1:0] c;
        c = word_byte();
        while (c == CH_DQUOTE || c == CH_SQUOTE) c = word_byte();
        line_buf.push_back(c);
        repeat ($urandom_range(0, 4)) line_buf.push_back(word_byte());
    endtask

    // A quoted word with escapes. When it ends the line it may be left open,
    // sometimes with an escape prefix as the very last byte.
    task automatic build_quoted(input bit ends_line);
        logic [BYTE_W-1:0] closer;
        closer = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        line_buf.push_back(closer);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(bslash_arg(closer));
                end
                2, 3: begin
                    line_buf.push_back(CH_CARET);
                    line_buf.push_back(caret_arg());
                end
                default: line_buf.push_back(quoted_byte(closer));
            endcase
        end
        if (ends_line && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0:       line_buf.push_back(CH_BSLASH);
                1:       line_buf.push_back(CH_CARET);
                default: ;
            endcase
        end else begin
            line_buf.push_back(closer);
            // The byte after the closing quote is swallowed whatever it is.
            line_buf.push_back($urandom_range(0, 1) ? blank_byte() : any_byte());
        end
    endtask

    // A well-formed line of a few words.
    task automatic build_line(input int n_words);
        line_buf.delete();
        if ($urandom_range(0, 3) == 0) line_buf.push_back(blank_byte());
        for (int i = 0; i < n_words; i++) begin
            if (i > 0) begin
                repeat ($urandom_range(1, 2)) line_buf.push_back(blank_byte());
            end
            if ($urandom_range(0, 1)) begin
                build_quoted(i == n_words - 1);
            end else begin
                build_plain();
            end
        end
        if ($urandom_range(0, 3) == 0) line_buf.push_back(blank_byte());
    endtask

    // Junk, weighted towards the bytes that steer the parser.
    task automatic build_noise();
        line_buf.delete();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 9))
                0:       line_buf.push_back(CH_DQUOTE);
                1:       line_buf.push_back(CH_SQUOTE);
                2:       line_buf.push_back(CH_BSLASH);
                3:       line_buf.push_back(CH_CARET);
                4:       line_buf.push_back(blank_byte());
                default: line_buf.push_back(any_byte());
            endcase
        end
    endtask

    // One-letter words just past the current limit, to run into the overflow.
    task automatic build_crowd();
        int n_words;
        n_words = (cur_limit > MAX_WORDS_D ? MAX_WORDS_D : cur_limit)
                  + $urandom_range(1, 3);
        line_buf.delete();
        for (int i = 0; i < n_words; i++) begin
            if (i > 0) line_buf.push_back(blank_byte());
            line_buf.push_back(BYTE_W'($urandom_range("a", "z")));
        end
    endtask

    // Random lines until the byte count reaches the given mark, with a fresh
    // limit every forty lines or so.
    task automatic random_lines(input int upto);
        int n_lines;
        int pick;
        n_lines = 0;
        while (bytes_sent < upto) begin
            if (n_lines % 40 == 39) set_limit(pick_limit());
            pick = $urandom_range(0, 99);
            if (pick < 1) begin
                build_crowd();
            end else if (pick < 16) begin
                build_noise();
            end else begin
                build_line($urandom_range(1, 6));
            end
            send_line();
            n_lines++;
        end
    endtask

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = '0;
        in_ch.last_byte   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.word_limit = '0;
        hold_request      = 1'b0;
        bytes_sent        = 0;
        cur_limit         = LIMIT_RESET;
        tx_idle_pct       = 27;
        rx_idle_pct       = 88;
        rst_n             = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed line under the reset limit: smallest and largest bytes, an
        // ending space, every caret class, a backslash before a plain letter,
        // a swallowed byte after each closing quote, the other quote kind
        // taken literally inside quotes, and a word that opens on the final byte.
        line_buf = '{8'h01, "b", 8'h20,
                     CH_DQUOTE, CH_BSLASH, "n", CH_BSLASH, "q",
                     CH_CARET, CH_QMARK, CH_CARET, CH_AT, CH_CARET, CH_UNDER,
                     CH_CARET, "z", CH_CARET, "1", CH_DQUOTE, "Z",
                     CH_SQUOTE, CH_DQUOTE, CH_SQUOTE, 8'h20, 8'hFF};
        send_line();

        // A limit of one: the second word stops the line on its final byte.
        set_limit(8'd1);
        line_buf = '{"x", 8'h20, "y"};
        send_line();
        // A quoted word left open with a backslash pending at the line end.
        line_buf = '{CH_SQUOTE, CH_BSLASH};
        send_line();

        // Sender idles lightly, receiver heavily.
        set_limit(8'd128);
        random_lines(620);

        // The other way round.
        tx_idle_pct = 88;
        rx_idle_pct = 27;
        set_limit(8'd1);
        random_lines(1240);

        // Neither side idles, apart from one long stall of the receiver.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_limit(pick_limit());
        hold_request = 1'b1;
        random_lines(1880);

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
